@@ hdl/sbat_pkg.sv @@
`timescale 1ns / 1ps

package sbat_pkg;

  localparam int unsigned MaxTreesDefault = 64;
  localparam int unsigned TreeW = 6;
  localparam int unsigned CellsW = 32;
  localparam int unsigned LifeW = 8;
  localparam int unsigned CountW = 16;

  localparam logic [LifeW-1:0] NewLifetime = LifeW'(3);
  localparam logic [LifeW-1:0] LifeMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_SPLIT = 2'd0,
    OP_AGE   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [TreeW-1:0]  tree;
    logic [CellsW-1:0] cells;
    logic              removed_empty;
  } req_t;

  typedef struct packed {
    logic             blacklisted;
    logic             present;
    logic [LifeW-1:0] lifetime_left;
  } rsp_t;

  typedef struct packed {
    logic [LifeW-1:0]  lifetime;
    logic [CellsW-1:0] cells_at_split;
    logic [CountW-1:0] split_count;
    logic [CountW-1:0] degenerate_count;
  } entry_t;

  typedef struct packed {
    logic we;
    logic set_present;
  } upd_t;

endpackage

@@ hdl/sbat_ram.sv @@
`timescale 1ns / 1ps

module sbat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sbat_update.sv @@
`timescale 1ns / 1ps

module sbat_update (
  input  sbat_pkg::req_t   req_i,
  input  logic             in_range_i,
  input  logic             present_i,
  input  sbat_pkg::entry_t rd_i,
  output sbat_pkg::entry_t wr_o,
  output sbat_pkg::upd_t   upd_o,
  output sbat_pkg::rsp_t   rsp_o
);

  import sbat_pkg::*;

  logic present;
  logic present_new;
  logic is_split;
  logic is_age;

  assign present  = present_i & in_range_i;
  assign is_split = (req_i.op == OP_SPLIT);
  assign is_age   = (req_i.op == OP_AGE);

  always_comb begin
    wr_o = rd_i;
    if (is_split) begin
      if (!present || rd_i.lifetime == '0) begin
        wr_o.lifetime         = NewLifetime;
        wr_o.cells_at_split   = req_i.cells;
        wr_o.split_count      = CountW'(1);
        wr_o.degenerate_count = '0;
      end else if (rd_i.split_count != CountMax) begin
        wr_o.split_count = rd_i.split_count + CountW'(1);
      end
    end else if (is_age) begin
      if (req_i.removed_empty) begin
        if (rd_i.degenerate_count != CountMax) begin
          wr_o.degenerate_count = rd_i.degenerate_count + CountW'(1);
        end
        if (rd_i.lifetime != LifeMax) begin
          wr_o.lifetime = rd_i.lifetime + LifeW'(1);
        end
      end else if (rd_i.lifetime != '0 && req_i.cells != rd_i.cells_at_split) begin
        wr_o.lifetime = rd_i.lifetime - LifeW'(1);
      end
    end
  end

  assign upd_o.we          = in_range_i & (is_split | (is_age & present));
  assign upd_o.set_present = in_range_i & is_split;

  assign present_new         = present | upd_o.set_present;
  assign rsp_o.present       = present_new;
  assign rsp_o.lifetime_left = present_new ? wr_o.lifetime : '0;
  assign rsp_o.blacklisted   = present_new & (wr_o.lifetime != '0);

endmodule

@@ hdl/split_blacklist_aging_table.sv @@
`timescale 1ns / 1ps
// split blacklist aging table
// input channel: in_valid_i / in_ready_o with one request in in_i (op, tree,
//   cells, removed_empty); op 0 records a split, op 1 ages the entry, op 2
//   and op 3 only query it
// output channel: out_valid_o / out_ready_i with one result in out_o
//   (blacklisted, present, lifetime_left) for every request, in order
// the entry is read from the table when a request is accepted; the result is loaded
//   into the output register when the update commits in the BUSY state
// no new request is taken until that update commits: the single table memory reads
//   the entry on acceptance, then BUSY writes it back and loads the result
// a new request is taken while the last result still waits in the output
//   register; if that result is not taken, the next update holds until it is
// reset: all present bits clear at once, no clearing pass; the other entry
//   fields need no reset since only a split makes an entry present
// tree numbers at or above MAX_TREES have no entry and report all zero

module split_blacklist_aging_table #(
  parameter int unsigned MAX_TREES = sbat_pkg::MaxTreesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sbat_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sbat_pkg::rsp_t out_o
);

  import sbat_pkg::*;

  localparam int unsigned NumEntries = (MAX_TREES < (2 ** TreeW)) ? MAX_TREES : (2 ** TreeW);
  localparam int unsigned AddrW = $clog2(NumEntries);
  localparam int unsigned EntryW = $bits(entry_t);

  state_e state_q, state_d;
  req_t req_q;
  logic [AddrW-1:0] addr_q;
  logic in_range_q;
  logic [NumEntries-1:0] present_q;
  rsp_t out_q;
  logic out_valid_q;

  logic accept;
  logic commit;
  logic in_range;
  logic [EntryW-1:0] rdata;
  entry_t rd_entry;
  entry_t wr_entry;
  upd_t upd;
  rsp_t rsp;
  logic ram_we;

  assign in_range = (32'(in_i.tree) < MAX_TREES);
  assign accept   = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= in_i;
      addr_q     <= AddrW'(in_i.tree);
      in_range_q <= in_range;
    end
  end

  sbat_ram #(
    .Width(EntryW),
    .Depth(NumEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(wr_entry),
    .re_i   (accept),
    .raddr_i(AddrW'(in_i.tree)),
    .rdata_o(rdata)
  );

  assign rd_entry = entry_t'(rdata);

  sbat_update u_update (
    .req_i     (req_q),
    .in_range_i(in_range_q),
    .present_i (present_q[addr_q]),
    .rd_i      (rd_entry),
    .wr_o      (wr_entry),
    .upd_o     (upd),
    .rsp_o     (rsp)
  );

  assign ram_we = commit & upd.we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (commit && upd.set_present) begin
      present_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_BUSY) && in_range_q)
    else $error("table write outside an update or for a tree beyond the table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY) && out_valid_q && !out_ready_i |=> (state_q == ST_BUSY))
    else $error("update finished while the pending result was not taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o && !accept)
    else $error("request accepted while the previous one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o && (out_o == $past(rsp)))
    else $error("result register not loaded on update");

endmodule
